[design/fire_reload_command_sequencer_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the fire/reload command sequencer
// ---------------------------------------------------------------------------
`ifndef FIRE_RELOAD_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define FIRE_RELOAD_COMMAND_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FRCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/frcs_pkg.sv]
// ---------------------------------------------------------------------------
// frcs_pkg
// Types and codes shared by the fire/reload command sequencer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package frcs_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACTION_TICKS = 2'd0;
  localparam logic [1:0] CFG_MAX_FIRES    = 2'd1;
  localparam logic [1:0] CFG_RELOAD_BASE  = 2'd2;
  localparam logic [1:0] CFG_ACCEPT_ID    = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0] ACTION_TICKS_RST = 16'd500;
  localparam logic [2:0]  MAX_FIRES_RST    = 3'd3;
  localparam logic [2:0]  RELOAD_BASE_RST  = 3'd4;
  localparam logic [10:0] ACCEPT_ID_RST    = 11'd0;

  // Command codes (first data byte)
  localparam logic [7:0] OPC_STOP   = 8'd0;
  localparam logic [7:0] OPC_FIRE   = 8'd1;
  localparam logic [7:0] OPC_RELOAD = 8'd2;
  localparam logic [7:0] OPC_QUERY  = 8'd3;

  // Request types
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Minimum data length of a command frame
  localparam logic [3:0] MIN_FRAME_LEN = 4'd2;

  // Reported machine state
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_RUNNING  = 2'd1;
  localparam logic [1:0] ST_FINISHED = 2'd2;
  localparam logic [1:0] ST_ERROR    = 2'd3;

  // Reported error
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_BUSY    = 2'd1;
  localparam logic [1:0] FAULT_SEQ     = 2'd2;
  localparam logic [1:0] FAULT_BAD_OPC = 2'd3;

  // Width of the reported reload servo mask
  localparam int unsigned MASK_W = 6;

  // Action in progress
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_FIRE   = 2'd1,
    ACT_RELOAD = 2'd2
  } action_e;

  // Classified item kind
  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_STOP,
    KIND_FIRE,
    KIND_RELOAD,
    KIND_QUERY,
    KIND_UNKNOWN
  } kind_e;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [10:0] frame_id;
    logic [0:0]  is_standard;
    logic [0:0]  is_data;
    logic [3:0]  frame_len;
    logic [7:0]  command_code;
    logic [7:0]  sequence_number;
  } in_item_t;

  typedef struct packed {
    logic [7:0] status_sequence;
    logic [1:0] status_state;
    logic [7:0] status_command;
    logic [1:0] status_error;
    logic [0:0] fire_servo_active;
    logic [5:0] reload_servo_mask;
  } out_item_t;

  // Queue entry between front and back
  typedef struct packed {
    kind_e      kind;
    logic [7:0] cmd;
    logic [7:0] seq;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] action_ticks;
    logic [2:0]  max_fires;
    logic [2:0]  reload_base;
    logic [10:0] accept_id;
  } cfg_t;

endpackage

`default_nettype wire

[design/frcs_front.sv]
// ---------------------------------------------------------------------------
// frcs_front
// Filters and classifies incoming frames and ticks, and buffers them in a
// two-entry queue toward the execution stage.
// ---------------------------------------------------------------------------
`default_nettype none

module frcs_front
  import frcs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          q_valid_o,
  input  wire logic     q_ready_i,
  output q_entry_t      q_entry_o
);

  localparam int unsigned DEPTH = 2;

  q_entry_t   mem_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  logic     keep;
  q_entry_t entry;
  logic     push, pop;

  // Classification: drop frames that do not address this node or fail the format and length checks
  always_comb begin
    entry.cmd  = in_data_i.command_code;
    entry.seq  = in_data_i.sequence_number;
    entry.kind = KIND_TICK;
    keep       = 1'b1;
    if (in_data_i.req_type == REQ_TICK) begin
      entry.kind = KIND_TICK;
    end else begin
      keep = (in_data_i.frame_id == cfg_i.accept_id) && in_data_i.is_standard[0] &&
             in_data_i.is_data[0] && (in_data_i.frame_len >= MIN_FRAME_LEN);
      unique case (in_data_i.command_code)
        OPC_STOP:   entry.kind = KIND_STOP;
        OPC_FIRE:   entry.kind = KIND_FIRE;
        OPC_RELOAD: entry.kind = KIND_RELOAD;
        OPC_QUERY:  entry.kind = KIND_QUERY;
        default:    entry.kind = KIND_UNKNOWN;
      endcase
    end
  end

  // Queue control
  assign in_ready_o = (count_q != 2'(DEPTH));
  assign push       = in_valid_i && in_ready_o && keep;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

[design/frcs_back.sv]
// ---------------------------------------------------------------------------
// frcs_back
// Executes classified commands and ticks against the sequencer state and
// holds the status result in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module frcs_back
  import frcs_pkg::*;
#(
  parameter int unsigned RELOAD_SRV_CNT = 6
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     q_valid_i,
  output logic          q_ready_o,
  input  wire q_entry_t q_entry_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  localparam int unsigned CNT_W = $clog2(RELOAD_SRV_CNT + 1);
  localparam int unsigned SRV_W = RELOAD_SRV_CNT + 1;

  action_e            act_q, act_d;
  logic [7:0]         last_cmd_q, last_cmd_d;
  logic [7:0]         act_seq_q, act_seq_d;
  logic [1:0]         mstate_q, mstate_d;
  logic [2:0]         fires_q, fires_d;
  logic [CNT_W-1:0]   rcnt_q, rcnt_d;
  logic [15:0]        elapsed_q, elapsed_d;
  logic [SRV_W-1:0]   servo_q, servo_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic               pop;
  logic               emit;
  logic [15:0]        elapsed_inc;
  logic [4:0]         n_sum;
  logic [CNT_W-1:0]   n_cap;
  logic [MASK_W-1:0]  mask;

  assign q_ready_o = !out_valid_q || out_ready_i;
  assign pop       = q_valid_i && q_ready_o;

  // Reload servo count: base plus fires minus one, capped
  assign n_sum = 5'(cfg_i.reload_base) + 5'(fires_q) - 5'd1;
  assign n_cap = (n_sum > 5'(RELOAD_SRV_CNT)) ? CNT_W'(RELOAD_SRV_CNT) : n_sum[CNT_W-1:0];

  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;

  // Reported mask: low reload servos of the next servo state
  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < RELOAD_SRV_CNT) begin : g_on
      assign mask[g] = servo_d[g+1];
    end else begin : g_off
      assign mask[g] = 1'b0;
    end
  end

  // Command execution
  always_comb begin
    act_d      = act_q;
    last_cmd_d = last_cmd_q;
    act_seq_d  = act_seq_q;
    mstate_d   = mstate_q;
    fires_d    = fires_q;
    rcnt_d     = rcnt_q;
    elapsed_d  = elapsed_q;
    servo_d    = servo_q;
    emit       = 1'b0;
    out_data_d.status_sequence = q_entry_i.seq;
    out_data_d.status_state    = ST_ERROR;
    out_data_d.status_command  = q_entry_i.cmd;
    out_data_d.status_error    = FAULT_NONE;
    if (pop) begin
      unique case (q_entry_i.kind) inside
        KIND_TICK: begin
          if (act_q != ACT_NONE) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= cfg_i.action_ticks) begin
              if (act_q == ACT_FIRE) begin
                servo_d[0] = 1'b0;
                if (4'(fires_q) + 4'd1 > 4'(cfg_i.max_fires)) begin
                  fires_d = cfg_i.max_fires;
                end else begin
                  fires_d = fires_q + 3'd1;
                end
              end else begin
                for (int i = 0; i < RELOAD_SRV_CNT; i++) begin
                  if (CNT_W'(i) < rcnt_q) begin
                    servo_d[i+1] = 1'b0;
                  end
                end
                if (fires_q >= cfg_i.max_fires) begin
                  fires_d = 3'd0;
                end
              end
              act_d    = ACT_NONE;
              mstate_d = ST_FINISHED;
              emit     = 1'b1;
              out_data_d.status_sequence = act_seq_q;
              out_data_d.status_state    = ST_FINISHED;
              out_data_d.status_command  = last_cmd_q;
            end
          end
        end
        KIND_STOP: begin
          servo_d    = '0;
          act_d      = ACT_NONE;
          last_cmd_d = OPC_STOP;
          act_seq_d  = q_entry_i.seq;
          mstate_d   = ST_IDLE;
          fires_d    = 3'd0;
          rcnt_d     = '0;
          elapsed_d  = 16'd0;
          emit       = 1'b1;
          out_data_d.status_state   = ST_FINISHED;
          out_data_d.status_command = OPC_STOP;
        end
        KIND_QUERY: begin
          emit = 1'b1;
          out_data_d.status_state   = mstate_q;
          out_data_d.status_command = last_cmd_q;
        end
        KIND_FIRE, KIND_RELOAD, KIND_UNKNOWN: begin
          emit = 1'b1;
          if (act_q != ACT_NONE) begin
            out_data_d.status_error = FAULT_BUSY;
          end else if (q_entry_i.kind == KIND_FIRE) begin
            act_d      = ACT_FIRE;
            last_cmd_d = OPC_FIRE;
            act_seq_d  = q_entry_i.seq;
            mstate_d   = ST_RUNNING;
            elapsed_d  = 16'd0;
            servo_d[0] = 1'b1;
            out_data_d.status_state   = ST_RUNNING;
            out_data_d.status_command = OPC_FIRE;
          end else if (q_entry_i.kind == KIND_RELOAD) begin
            out_data_d.status_command = OPC_RELOAD;
            if (fires_q == 3'd0) begin
              out_data_d.status_error = FAULT_SEQ;
            end else begin
              rcnt_d     = n_cap;
              act_d      = ACT_RELOAD;
              last_cmd_d = OPC_RELOAD;
              act_seq_d  = q_entry_i.seq;
              mstate_d   = ST_RUNNING;
              elapsed_d  = 16'd0;
              for (int i = 0; i < RELOAD_SRV_CNT; i++) begin
                if (CNT_W'(i) < n_cap) begin
                  servo_d[i+1] = 1'b1;
                end
              end
              out_data_d.status_state = ST_RUNNING;
            end
          end else begin
            out_data_d.status_error = FAULT_BAD_OPC;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    out_data_d.fire_servo_active = servo_d[0];
    out_data_d.reload_servo_mask = mask;
  end

  // Output register valid
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= ACT_NONE;
      last_cmd_q  <= 8'd0;
      act_seq_q   <= 8'd0;
      mstate_q    <= ST_IDLE;
      fires_q     <= 3'd0;
      rcnt_q      <= '0;
      elapsed_q   <= 16'd0;
      servo_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      last_cmd_q  <= last_cmd_d;
      act_seq_q   <= act_seq_d;
      mstate_q    <= mstate_d;
      fires_q     <= fires_d;
      rcnt_q      <= rcnt_d;
      elapsed_q   <= elapsed_d;
      servo_q     <= servo_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[design/fire_reload_command_sequencer_core.sv]
// ---------------------------------------------------------------------------
// fire_reload_command_sequencer_core
// Command sequencer for a fire servo and a bank of reload servos, driven by
// received command frames and a millisecond tick.
// ---------------------------------------------------------------------------
// Takes one transaction per clock cycle while the queue has room. A front
// stage filters frames on identifier, format and length, classifies the
// command and puts it in a two-entry queue; the execution stage takes one
// queued entry per cycle while its output register is free or being read, and
// writes its status into that register. Rejected frames and ticks that finish
// nothing produce no result. The queue keeps accepting while a result waits to
// be taken; input stalls only when the queue is full. No clearing pass after
// reset. Configuration writes take effect on the next cycle.
`default_nettype none

module fire_reload_command_sequencer_core
  import frcs_pkg::*;
#(
  parameter int unsigned RELOAD_SRV_CNT = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o
);

  cfg_t     cfg_q, cfg_d;
  logic     q_valid, q_ready;
  q_entry_t q_entry;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTION_TICKS: cfg_d.action_ticks = cfg_wdata_i;
        CFG_MAX_FIRES:    cfg_d.max_fires    = cfg_wdata_i[2:0];
        CFG_RELOAD_BASE:  cfg_d.reload_base  = cfg_wdata_i[2:0];
        CFG_ACCEPT_ID:    cfg_d.accept_id    = cfg_wdata_i[10:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.action_ticks <= ACTION_TICKS_RST;
      cfg_q.max_fires    <= MAX_FIRES_RST;
      cfg_q.reload_base  <= RELOAD_BASE_RST;
      cfg_q.accept_id    <= ACCEPT_ID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: filter, classify, queue
  frcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_entry_o  (q_entry)
  );

  // Back: execute and report
  frcs_back #(
    .RELOAD_SRV_CNT (RELOAD_SRV_CNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_entry_i   (q_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Assertions
  `include "fire_reload_command_sequencer_core_assert.svh"

  `FRCS_ASSERT_IMPL(a_pop_needs_room, q_valid && q_ready, !out_valid_o || out_ready_i, "execution with a blocked result")
  `FRCS_ASSERT_IMPL(a_full_has_data, !in_ready_o, q_valid, "input stalled with an empty queue")
  `FRCS_ASSERT_NEXT(a_result_from_pop, !out_valid_o, !out_valid_o || $past(q_valid && q_ready), "result without execution")

endmodule

`default_nettype wire
